// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// Compacting list table package
// Operation codes, status codes, cell commands and controller states shared
// by the list controller, the storage cells and the top level.
// ----------------------------------------------------------------------------
package clt_pkg;

    // Operation codes carried in the mode field of an input word.
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SEARCH = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Status codes carried in the status field of an output word.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_MISS  = 2'd3;

    // Command broadcast from the controller to every storage cell.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ----- rtl/clt_cell.sv -----
// ----------------------------------------------------------------------------
// Compacting list table storage cell
// Holds one list entry and takes a new word from the input or from its
// right-hand neighbor as the broadcast command says.
// ----------------------------------------------------------------------------
module clt_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5,
    parameter int MY_IDX     = 0
) (
    input  logic                  clk,
    input  clt_pkg::cell_op_t     op,
    input  logic [IDX_W-1:0]      index,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] nbr,
    output logic [DATA_WIDTH-1:0] entry
);
    import clt_pkg::*;

    localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(MY_IDX);
    localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(MY_IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_APPEND:
            begin
                // Only the first free slot takes the new word.
                if (count == POS_CNT)
                begin
                    entry_next = value;
                end
            end
            CELL_REMOVE:
            begin
                // Every slot at or above the removed one moves down by one place.
                if (POS_IDX >= index)
                begin
                    entry_next = nbr;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = nbr;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/clt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Compacting list table controller
// Decodes requests, keeps the entry count, steps the cell chain through a
// full rotation for search and read, and buffers results toward the output.
// ----------------------------------------------------------------------------
module clt_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [IDX_W-1:0]      index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [IDX_W-1:0]      position,
    output logic [DATA_WIDTH-1:0] read_data,
    output logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] head,
    output clt_pkg::cell_op_t     cell_op,
    output logic [IDX_W-1:0]      cell_index,
    output logic [CNT_W-1:0]      cell_count,
    output logic [DATA_WIDTH-1:0] cell_value
);
    import clt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    // Scan working registers.
    logic [IDX_W-1:0]      step_reg, step_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_pos_reg, hit_pos_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [2:0]            op_mode_reg, op_mode_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]      sel_reg, sel_next;

    // Pending result and output register.
    logic                  pend_valid_reg;
    logic [1:0]            pend_status_reg;
    logic [IDX_W-1:0]      pend_pos_reg;
    logic [DATA_WIDTH-1:0] pend_rd_reg;
    logic [CNT_W-1:0]      pend_count_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [IDX_W-1:0]      out_pos_reg;
    logic [DATA_WIDTH-1:0] out_rd_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  out_free;
    logic                  pend_free;
    logic                  accept;
    logic                  res_load;
    logic [1:0]            res_status;
    logic [IDX_W-1:0]      res_pos;
    logic [DATA_WIDTH-1:0] res_rd;

    assign out_free  = !out_valid_reg || out_ready;
    assign pend_free = !pend_valid_reg || out_free;
    assign in_ready  = (state_reg == ST_IDLE) && pend_free;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        hit_pos_next = hit_pos_reg;
        rd_next      = rd_reg;
        op_mode_next = op_mode_reg;
        key_next     = key_reg;
        sel_next     = sel_reg;
        cell_op      = CELL_HOLD;
        res_load     = 1'b0;
        res_status   = STAT_OK;
        res_pos      = '0;
        res_rd       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_APPEND:
                        begin
                            res_load = 1'b1;
                            if (count_reg != FULL_CNT)
                            begin
                                cell_op    = CELL_APPEND;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status = STAT_FULL;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            res_load = 1'b1;
                            if (CNT_W'(index) < count_reg)
                            begin
                                cell_op    = CELL_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status = STAT_RANGE;
                            end
                        end
                        MODE_SEARCH, MODE_READ:
                        begin
                            state_next   = ST_SCAN;
                            step_next    = '0;
                            found_next   = 1'b0;
                            hit_pos_next = '0;
                            rd_next      = '0;
                            op_mode_next = mode;
                            key_next     = value;
                            sel_next     = index;
                        end
                        MODE_CLEAR:
                        begin
                            res_load   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // The entry at position step_reg sits in the head cell now.
                cell_op   = CELL_ROTATE;
                step_next = step_reg + IDX_W'(1);
                if (op_mode_reg == MODE_SEARCH)
                begin
                    if (!found_reg && (CNT_W'(step_reg) < count_reg) && (head == key_reg))
                    begin
                        found_next   = 1'b1;
                        hit_pos_next = step_reg;
                    end
                end
                else if ((step_reg == sel_reg) && (CNT_W'(sel_reg) < count_reg))
                begin
                    rd_next = head;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (pend_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (op_mode_reg == MODE_SEARCH)
                    begin
                        res_status = found_reg ? STAT_OK : STAT_MISS;
                        res_pos    = hit_pos_reg;
                    end
                    else
                    begin
                        res_status = (CNT_W'(sel_reg) < count_reg) ? STAT_OK : STAT_RANGE;
                        res_rd     = rd_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cell_index = index;
    assign cell_count = count_reg;
    assign cell_value = value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= res_load || (pend_valid_reg && !out_free);
            if (out_free)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        found_reg   <= found_next;
        hit_pos_reg <= hit_pos_next;
        rd_reg      <= rd_next;
        op_mode_reg <= op_mode_next;
        key_reg     <= key_next;
        sel_reg     <= sel_next;
        if (res_load)
        begin
            pend_status_reg <= res_status;
            pend_pos_reg    <= res_pos;
            pend_rd_reg     <= res_rd;
            pend_count_reg  <= count_next;
        end
        if (out_free && pend_valid_reg)
        begin
            out_status_reg <= pend_status_reg;
            out_pos_reg    <= pend_pos_reg;
            out_rd_reg     <= pend_rd_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign position  = out_pos_reg;
    assign read_data = out_rd_reg;
    assign count     = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds depth");

    a_scan_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && step_reg != LAST_STEP) |=> (state_reg == ST_SCAN))
        else $error("scan left before a full rotation");

    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("count changed during a scan");

    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !out_free) |=> pend_valid_reg)
        else $error("pending result lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> pend_free)
        else $error("result loaded over a pending result");

endmodule

// ----- rtl/compacting_list_table.sv -----
// ----------------------------------------------------------------------------
// Compacting list table
// A fixed-depth list of words in insertion order with append, remove,
// search, read and clear, built as a ring of storage cells.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Word contents
//   -------   ---------------------   ------------------------------------
//   input     in_valid / in_ready     mode, value, index
//   output    out_valid / out_ready   status, position, read_data, count
//
// Append, remove, clear and the unused modes load their result in the
// accepting cycle; back to back words of these kinds are accepted every
// cycle while the pending register is free. For search and read, the
// accepting cycle is followed by a scan, in which the cell ring rotates
// once around presenting one entry per cycle at the head cell, and by a
// done state that loads the result; the input is held off until that load.
// Reset clears the entry count and all handshake state; the entries are not
// cleared and need no clearing pass, since only entries below the count are
// ever reported.
// A result waits in a pending register and then in the output register, so
// a stalled output still lets one further word in before the input stalls.
// ----------------------------------------------------------------------------
module compacting_list_table #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    mode,
    input  logic [DATA_WIDTH-1:0]         value,
    input  logic [$clog2(DEPTH)-1:0]      index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [$clog2(DEPTH)-1:0]      position,
    output logic [DATA_WIDTH-1:0]         read_data,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import clt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Command and operands broadcast to every cell.
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      cell_index;
    logic [CNT_W-1:0]      cell_count;
    logic [DATA_WIDTH-1:0] cell_value;

    // Contents of each cell; cell 0 is the head of the list.
    logic [DATA_WIDTH-1:0] entry [DEPTH];

    clt_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .position   (position),
        .read_data  (read_data),
        .count      (count),
        .head       (entry[0]),
        .cell_op    (cell_op),
        .cell_index (cell_index),
        .cell_count (cell_count),
        .cell_value (cell_value)
    );

    // Each cell takes its right-hand neighbor's word on a remove or a
    // rotation; the last cell wraps around to the head so that a full
    // rotation puts every entry back where it started.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        clt_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .MY_IDX     (i)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .index (cell_index),
            .count (cell_count),
            .value (cell_value),
            .nbr   (entry[(i + 1) % DEPTH]),
            .entry (entry[i])
        );
    end

endmodule
